// ===== rtl/uuwg_pkg.sv =====
package uuwg_pkg;

  localparam int GRID_DIM_DEF  = 512;
  localparam int CNT_W         = 24;
  localparam int SCALE_W       = 32;
  localparam int COORD_W       = 32;
  localparam int FREQ_W        = 34;
  localparam int POLC_W        = 3;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POL_COUNT  = 2'd1;

  localparam logic [CNT_W-1:0] COUNT_MAX  = 24'hFFFFFF;
  localparam logic [CNT_W-1:0] WEIGHT_ONE = 24'd8388608;

  localparam logic OP_ACCUM  = 1'b0;
  localparam logic OP_WEIGHT = 1'b1;

endpackage

// ===== rtl/uuwg_ram.sv =====
module uuwg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/uniform_uv_weighting_grid.sv =====
// Sequential block, one transaction at a time; in_ready is high only when idle.
// Accumulate: address mapping, cell read and count update complete before the next item can be taken.
// Weight: address mapping, a divider (skipped for an empty or off-grid cell), then pol_count results.
// Address mapping is set by one shared 32x34 multiplier, used three times per axis.
// Reset (rst, synchronous) clears the count memory one entry per cycle, all
// GRID_DIM*GRID_DIM entries; no input is accepted until the clear is done.
module uniform_uv_weighting_grid #(
  parameter int GRID_DIM = uuwg_pkg::GRID_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [uuwg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uuwg_pkg::SCALE_W-1:0]       cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               opcode,
  input  logic signed [uuwg_pkg::COORD_W-1:0] u_metres,
  input  logic signed [uuwg_pkg::COORD_W-1:0] v_metres,
  input  logic [uuwg_pkg::FREQ_W-1:0]        freq_hz,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [uuwg_pkg::CNT_W-1:0]         weight,
  output logic                               in_grid,
  output logic [1:0]                         pol_index,
  output logic                               last
);
  import uuwg_pkg::*;

  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(GRID_DIM);
  localparam int HALF  = GRID_DIM / 2;
  localparam int PW    = SCALE_W + FREQ_W;
  localparam int TW    = 2 * SCALE_W + FREQ_W;
  localparam int DIV_W = CNT_W + 1;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MUL0  = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_ADR   = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]             state;
  logic [SCALE_W-1:0]     grid_scale;
  logic [1:0]             npol;
  logic [AW-1:0]          clr_addr;

  logic                   op;
  logic [COORD_W-1:0]     u_raw, v_raw;
  logic [FREQ_W-1:0]      freq;
  logic                   axis;
  logic [2*SCALE_W-1:0]   p1;
  logic [PW-1:0]          m_lo, m_hi;
  logic [IW-1:0]          iu, iv;
  logic                   ok_u, in_range;
  logic [AW-1:0]          cell_addr;

  logic [DIV_W:0]         rem;
  logic [DIV_W-1:0]       num;
  logic [DIV_W-1:0]       quo;
  logic [CNT_W-1:0]       dvs;
  logic [4:0]             div_cnt;

  logic [CNT_W-1:0]       weight_r;
  logic                   in_grid_r;
  logic [1:0]             pol_r;

  logic [COORD_W-1:0]     raw;
  logic [COORD_W-1:0]     mag;
  logic [SCALE_W-1:0]     mul_a;
  logic [FREQ_W-1:0]      mul_b;
  logic [PW-1:0]          mul_p;
  logic [TW-1:0]          total;
  logic [FREQ_W-1:0]      hi;
  logic                   lo_nz;
  logic [FREQ_W-1:0]      r;
  logic                   ax_ok;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [CNT_W-1:0]       ram_wdata;
  logic [CNT_W-1:0]       ram_rdata;

  logic [DIV_W:0]         trial;
  logic                   qbit;

  uuwg_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    raw   = axis ? v_raw : u_raw;
    mag   = raw[COORD_W-1] ? (~raw + 1'b1) : raw;
    mul_a = SCALE_W'(mag);
    mul_b = FREQ_W'(grid_scale);
    case (state)
      S_MUL1: begin
        mul_a = p1[SCALE_W-1:0];
        mul_b = freq;
      end
      S_MUL2: begin
        mul_a = p1[2*SCALE_W-1:SCALE_W];
        mul_b = freq;
      end
      default: ;
    endcase
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  always_comb begin
    total = {m_hi, {SCALE_W{1'b0}}} + TW'(m_lo);
    hi    = total[TW-1:2*SCALE_W];
    lo_nz = |total[2*SCALE_W-1:0];
    if (!raw[COORD_W-1]) begin
      r     = FREQ_W'(HALF) + hi;
      ax_ok = (hi < FREQ_W'(GRID_DIM)) && (r < FREQ_W'(GRID_DIM));
    end else if (hi == FREQ_W'(HALF)) begin
      r     = '0;
      ax_ok = 1'b1;
    end else begin
      r     = FREQ_W'(HALF) - hi - FREQ_W'(lo_nz);
      ax_ok = hi < FREQ_W'(HALF);
    end
  end

  always_comb begin
    trial = {rem[DIV_W-1:0], num[DIV_W-1]};
    qbit  = trial >= (DIV_W+1)'(dvs);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = ram_rdata + 1'b1;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_CHK && op == OP_ACCUM && in_range && ram_rdata != COUNT_MAX) begin
      ram_we = 1'b1;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign weight    = weight_r;
  assign in_grid   = in_grid_r;
  assign pol_index = pol_r;
  assign last      = (pol_r == npol);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_scale <= '0;
      npol       <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_GRID_SCALE) begin
        grid_scale <= cfg_data;
      end else if (cfg_index == REG_POL_COUNT) begin
        case (cfg_data[POLC_W-1:0])
          3'd0, 3'd1: npol <= 2'd0;
          3'd2:       npol <= 2'd1;
          3'd3:       npol <= 2'd2;
          default:    npol <= 2'd3;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      axis     <= 1'b0;
      pol_r    <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op    <= opcode;
            u_raw <= u_metres;
            v_raw <= v_metres;
            freq  <= freq_hz;
            axis  <= 1'b0;
            state <= S_MUL0;
          end
        end
        S_MUL0: begin
          p1    <= mul_p[2*SCALE_W-1:0];
          state <= S_MUL1;
        end
        S_MUL1: begin
          m_lo  <= mul_p;
          state <= S_MUL2;
        end
        S_MUL2: begin
          m_hi  <= mul_p;
          state <= S_SUM;
        end
        S_SUM: begin
          if (!axis) begin
            iu    <= r[IW-1:0];
            ok_u  <= ax_ok;
            axis  <= 1'b1;
            state <= S_MUL0;
          end else begin
            iv       <= r[IW-1:0];
            in_range <= ok_u && ax_ok;
            state    <= S_ADR;
          end
        end
        S_ADR: begin
          cell_addr <= AW'(iv) * AW'(GRID_DIM) + AW'(iu);
          state     <= S_RD;
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          in_grid_r <= in_range;
          pol_r     <= '0;
          if (op == OP_ACCUM) begin
            state <= S_IDLE;
          end else if (in_range && ram_rdata != '0) begin
            num     <= DIV_W'(WEIGHT_ONE) + DIV_W'(ram_rdata >> 1);
            dvs     <= ram_rdata;
            rem     <= '0;
            quo     <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end else begin
            weight_r <= WEIGHT_ONE;
            state    <= S_OUT;
          end
        end
        S_DIV: begin
          rem     <= qbit ? (trial - (DIV_W+1)'(dvs)) : trial;
          num     <= {num[DIV_W-2:0], 1'b0};
          quo     <= {quo[DIV_W-2:0], qbit};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 5'(DIV_W - 1)) begin
            weight_r <= {quo[CNT_W-2:0], qbit};
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (pol_r == npol) begin
              state <= S_IDLE;
            end else begin
              pol_r <= pol_r + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
